>>> sv/mphc_pkg.sv
// ----------------------------------------------------------------------------
// mphc_pkg
// shared widths, reset values, event codes and helpers for the moisture pump
// hysteresis controller
// ----------------------------------------------------------------------------
package mphc_pkg;

   localparam int ADC_BITS      = 12;
   localparam int TIMER_BITS    = 16;
   localparam int PERIOD_BITS   = 16;
   localparam int DEB_BITS      = 10;
   localparam int PCT_BITS      = 7;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int NUM_BITS      = ADC_BITS + PCT_BITS;
   localparam int DIV_CNT_BITS  = $clog2(NUM_BITS + 1);

   localparam logic [PCT_BITS-1:0]   PCT_FULL     = PCT_BITS'(100);
   localparam logic [PCT_BITS-1:0]   REPORT_CLAMP = PCT_BITS'(99);
   localparam logic [TIMER_BITS-1:0] TIMER_MAX    = '1;

   localparam logic [ADC_BITS-1:0]    RST_WET      = ADC_BITS'(1090);
   localparam logic [ADC_BITS-1:0]    RST_DRY      = ADC_BITS'(4095);
   localparam logic [PCT_BITS-1:0]    RST_START    = PCT_BITS'(35);
   localparam logic [PCT_BITS-1:0]    RST_STOP     = PCT_BITS'(45);
   localparam logic [PERIOD_BITS-1:0] RST_MAX_ON   = PERIOD_BITS'(10000);
   localparam logic [PERIOD_BITS-1:0] RST_CONTROL  = PERIOD_BITS'(100);
   localparam logic [PERIOD_BITS-1:0] RST_REPORT   = PERIOD_BITS'(2000);
   localparam logic [DEB_BITS-1:0]    RST_DEBOUNCE = DEB_BITS'(30);

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_EMPTY  = 3'd1,
      EV_REFILL = 3'd2,
      EV_REPORT = 3'd3,
      EV_START  = 3'd4
   } event_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_WET      = 3'd0,
      REG_DRY      = 3'd1,
      REG_START    = 3'd2,
      REG_STOP     = 3'd3,
      REG_MAX_ON   = 3'd4,
      REG_CONTROL  = 3'd5,
      REG_REPORT   = 3'd6,
      REG_DEBOUNCE = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic apply;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic ctl_due;
      logic div_done;
      logic last;
   } status_type;

   function automatic logic [TIMER_BITS-1:0] tick_up(input logic [TIMER_BITS-1:0] v);
      return (v == TIMER_MAX) ? v : v + TIMER_BITS'(1);
   endfunction

   function automatic logic timer_ge(input logic [TIMER_BITS-1:0] cnt,
                                     input logic [PERIOD_BITS-1:0] lim);
      return 32'(cnt) >= 32'(lim);
   endfunction

endpackage

>>> sv/moisture_pump_hysteresis_controller_top.sv
// ----------------------------------------------------------------------------
// moisture_pump_hysteresis_controller_top
// soil moisture pump controller with float debounce, hysteresis and an
// on-time limit; one request per millisecond tick, one to three responses
//
//   channel  handshake               payload
//   req      req_valid / req_ready   float_low, float_edge, moisture_adc
//   rsp      rsp_valid / rsp_ready   pump_on, event_res, humidity_report, last
//   csr      csr_we                  csr_index, csr_wdata (write only)
//
// a tick loads its request, checks for a control step, then hands out its
// responses one per transfer; a control step runs the 19-step restoring divide
// between the check and the first response
// synchronous reset loads the register defaults; no clearing pass
// a stalled response holds the sequencer; no request is taken until the
// last response of the tick is transferred
// ----------------------------------------------------------------------------
module moisture_pump_hysteresis_controller_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mphc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [mphc_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_float_low,
   input  logic                                req_float_edge,
   input  logic [mphc_pkg::ADC_BITS-1:0]       req_moisture_adc,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_pump_on,
   output logic [2:0]                          rsp_event_res,
   output logic [mphc_pkg::PCT_BITS-1:0]       rsp_humidity_report,
   output logic                                rsp_last
);

   mphc_pkg::cmd_type    cmd;
   mphc_pkg::status_type status;

   mphc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mphc_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_float_low       (req_float_low),
      .req_float_edge      (req_float_edge),
      .req_moisture_adc    (req_moisture_adc),
      .cmd                 (cmd),
      .status              (status),
      .rsp_pump_on         (rsp_pump_on),
      .rsp_event_res       (rsp_event_res),
      .rsp_humidity_report (rsp_humidity_report),
      .rsp_last            (rsp_last)
   );

endmodule

>>> sv/mphc_div.sv
// ----------------------------------------------------------------------------
// mphc_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mphc_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [mphc_pkg::NUM_BITS-1:0]  num,
   input  logic [mphc_pkg::ADC_BITS-1:0]  den,
   output logic                           done,
   output logic [mphc_pkg::NUM_BITS-1:0]  quot
);

   logic [mphc_pkg::DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [mphc_pkg::ADC_BITS-1:0]     rem_ff, rem_in;
   logic [mphc_pkg::NUM_BITS-1:0]     quot_ff, quot_in;
   logic [mphc_pkg::ADC_BITS-1:0]     den_ff, den_in;
   logic                              done_ff, done_in;
   logic [mphc_pkg::ADC_BITS:0]       shifted;
   logic [mphc_pkg::ADC_BITS:0]       diff;
   logic                              fits;

   always_comb begin
      shifted = {rem_ff, quot_ff[mphc_pkg::NUM_BITS-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in  = mphc_pkg::DIV_CNT_BITS'(mphc_pkg::NUM_BITS);
         rem_in  = '0;
         quot_in = num;
         den_in  = den;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - mphc_pkg::DIV_CNT_BITS'(1);
         rem_in  = fits ? diff[mphc_pkg::ADC_BITS-1:0] : shifted[mphc_pkg::ADC_BITS-1:0];
         quot_in = {quot_ff[mphc_pkg::NUM_BITS-2:0], fits};
         done_in = cnt_ff == mphc_pkg::DIV_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> sv/mphc_dp.sv
// ----------------------------------------------------------------------------
// mphc_dp
// configuration registers, tick counters, float debounce, percent mapping,
// pump decision and result selection
// ----------------------------------------------------------------------------
module mphc_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mphc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [mphc_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                                req_float_low,
   input  logic                                req_float_edge,
   input  logic [mphc_pkg::ADC_BITS-1:0]       req_moisture_adc,
   input  mphc_pkg::cmd_type                   cmd,
   output mphc_pkg::status_type                status,
   output logic                                rsp_pump_on,
   output logic [2:0]                          rsp_event_res,
   output logic [mphc_pkg::PCT_BITS-1:0]       rsp_humidity_report,
   output logic                                rsp_last
);

   // configuration
   logic [mphc_pkg::ADC_BITS-1:0]    wet_ff, dry_ff;
   logic [mphc_pkg::PCT_BITS-1:0]    start_thr_ff, stop_thr_ff;
   logic [mphc_pkg::PERIOD_BITS-1:0] max_on_ff, control_ff, report_ff;
   logic [mphc_pkg::DEB_BITS-1:0]    debounce_ff;

   // tick state
   logic                             started_ff, started_in;
   logic                             tank_empty_ff, tank_empty_in;
   logic                             pump_ff, pump_in;
   logic                             pend_ff, pend_in;
   logic                             target_ff, target_in;
   logic [mphc_pkg::DEB_BITS-1:0]    settle_ff, settle_in;
   logic [mphc_pkg::TIMER_BITS-1:0]  since_ctl_ff, since_ctl_in;
   logic [mphc_pkg::TIMER_BITS-1:0]  since_rep_ff, since_rep_in;
   logic [mphc_pkg::TIMER_BITS-1:0]  elapsed_ff, elapsed_in;
   logic [mphc_pkg::ADC_BITS-1:0]    adc_ff, adc_in;
   logic                             due_ff, due_in;

   // pending results: bit 0 tank, bit 1 report, bit 2 watering started
   logic [2:0]                       mask_ff, mask_in;
   mphc_pkg::event_type              tank_ev_ff, tank_ev_in;
   logic [mphc_pkg::PCT_BITS-1:0]    rep_pct_ff, rep_pct_in;

   // percent mapping
   logic [mphc_pkg::ADC_BITS:0]      num_diff, den_diff;
   logic [mphc_pkg::ADC_BITS-1:0]    num_mag, den_mag;
   logic [mphc_pkg::NUM_BITS-1:0]    num_scaled, quot;
   logic                             pct_zero, div_done;
   logic [mphc_pkg::PCT_BITS-1:0]    pct;
   mphc_pkg::event_type              cur_ev;

   always_comb begin
      num_diff   = {1'b0, dry_ff} - {1'b0, adc_ff};
      den_diff   = {1'b0, dry_ff} - {1'b0, wet_ff};
      num_mag    = num_diff[mphc_pkg::ADC_BITS] ? num_diff[mphc_pkg::ADC_BITS-1:0] ^ '1
                   : num_diff[mphc_pkg::ADC_BITS-1:0];
      if (num_diff[mphc_pkg::ADC_BITS]) begin
         num_mag = num_mag + mphc_pkg::ADC_BITS'(1);
      end
      den_mag    = den_diff[mphc_pkg::ADC_BITS] ? den_diff[mphc_pkg::ADC_BITS-1:0] ^ '1
                   : den_diff[mphc_pkg::ADC_BITS-1:0];
      if (den_diff[mphc_pkg::ADC_BITS]) begin
         den_mag = den_mag + mphc_pkg::ADC_BITS'(1);
      end
      num_scaled = mphc_pkg::NUM_BITS'(num_mag) * mphc_pkg::NUM_BITS'(mphc_pkg::PCT_FULL);
      // negative quotients clamp to zero, equal references give zero
      pct_zero   = (den_diff == '0) || (num_diff == '0) ||
                   (num_diff[mphc_pkg::ADC_BITS] != den_diff[mphc_pkg::ADC_BITS]);
      if (pct_zero) begin
         pct = '0;
      end else if (quot > mphc_pkg::NUM_BITS'(mphc_pkg::PCT_FULL)) begin
         pct = mphc_pkg::PCT_FULL;
      end else begin
         pct = quot[mphc_pkg::PCT_BITS-1:0];
      end
   end

   mphc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_scaled),
      .den   (den_mag),
      .done  (div_done),
      .quot  (quot)
   );

   always_comb begin
      logic prev_empty;
      prev_empty   = tank_empty_ff;
      started_in   = started_ff;
      tank_empty_in = tank_empty_ff;
      pump_in      = pump_ff;
      pend_in      = pend_ff;
      target_in    = target_ff;
      settle_in    = settle_ff;
      since_ctl_in = since_ctl_ff;
      since_rep_in = since_rep_ff;
      elapsed_in   = elapsed_ff;
      adc_in       = adc_ff;
      due_in       = due_ff;
      mask_in      = mask_ff;
      tank_ev_in   = tank_ev_ff;
      rep_pct_in   = rep_pct_ff;

      if (cmd.load) begin
         adc_in  = req_moisture_adc;
         mask_in = '0;
         due_in  = 1'b0;
         if (!started_ff) begin
            started_in    = 1'b1;
            tank_empty_in = req_float_low;
         end else begin
            since_ctl_in = mphc_pkg::tick_up(since_ctl_ff);
            since_rep_in = mphc_pkg::tick_up(since_rep_ff);
            if (pump_ff) begin
               elapsed_in = mphc_pkg::tick_up(elapsed_ff);
            end
            if (req_float_edge) begin
               pend_in   = 1'b1;
               target_in = req_float_low;
               settle_in = debounce_ff;
            end
            if (pend_in) begin
               if (settle_in == '0) begin
                  pend_in = 1'b0;
                  if (req_float_low == target_in) begin
                     tank_empty_in = req_float_low;
                     if (!prev_empty && req_float_low) begin
                        mask_in[0] = 1'b1;
                        tank_ev_in = mphc_pkg::EV_EMPTY;
                        pump_in    = 1'b0;
                     end else if (prev_empty && !req_float_low) begin
                        mask_in[0] = 1'b1;
                        tank_ev_in = mphc_pkg::EV_REFILL;
                     end
                  end
               end else begin
                  settle_in = settle_in - mphc_pkg::DEB_BITS'(1);
               end
            end
            if (mphc_pkg::timer_ge(since_ctl_in, control_ff)) begin
               due_in       = 1'b1;
               since_ctl_in = '0;
               if (mphc_pkg::timer_ge(since_rep_in, report_ff)) begin
                  since_rep_in = '0;
                  mask_in[1]   = 1'b1;
               end
            end
         end
      end

      if (cmd.apply) begin
         rep_pct_in = (pct > mphc_pkg::REPORT_CLAMP) ? mphc_pkg::REPORT_CLAMP : pct;
         if (!pump_ff) begin
            if (!tank_empty_ff && pct <= start_thr_ff) begin
               pump_in    = 1'b1;
               elapsed_in = '0;
               mask_in[2] = 1'b1;
            end
         end else if (mphc_pkg::timer_ge(elapsed_ff, max_on_ff) || pct >= stop_thr_ff ||
                      tank_empty_ff) begin
            pump_in = 1'b0;
         end
      end

      if (cmd.pop) begin
         mask_in = mask_ff & (mask_ff - 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wet_ff        <= mphc_pkg::RST_WET;
         dry_ff        <= mphc_pkg::RST_DRY;
         start_thr_ff  <= mphc_pkg::RST_START;
         stop_thr_ff   <= mphc_pkg::RST_STOP;
         max_on_ff     <= mphc_pkg::RST_MAX_ON;
         control_ff    <= mphc_pkg::RST_CONTROL;
         report_ff     <= mphc_pkg::RST_REPORT;
         debounce_ff   <= mphc_pkg::RST_DEBOUNCE;
         started_ff    <= 1'b0;
         tank_empty_ff <= 1'b0;
         pump_ff       <= 1'b0;
         pend_ff       <= 1'b0;
         target_ff     <= 1'b0;
         settle_ff     <= '0;
         since_ctl_ff  <= '0;
         since_rep_ff  <= '0;
         elapsed_ff    <= '0;
         due_ff        <= 1'b0;
         mask_ff       <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               mphc_pkg::REG_WET:      wet_ff       <= csr_wdata[mphc_pkg::ADC_BITS-1:0];
               mphc_pkg::REG_DRY:      dry_ff       <= csr_wdata[mphc_pkg::ADC_BITS-1:0];
               mphc_pkg::REG_START:    start_thr_ff <= csr_wdata[mphc_pkg::PCT_BITS-1:0];
               mphc_pkg::REG_STOP:     stop_thr_ff  <= csr_wdata[mphc_pkg::PCT_BITS-1:0];
               mphc_pkg::REG_MAX_ON:   max_on_ff    <= csr_wdata[mphc_pkg::PERIOD_BITS-1:0];
               mphc_pkg::REG_CONTROL:  control_ff   <= csr_wdata[mphc_pkg::PERIOD_BITS-1:0];
               mphc_pkg::REG_REPORT:   report_ff    <= csr_wdata[mphc_pkg::PERIOD_BITS-1:0];
               mphc_pkg::REG_DEBOUNCE: debounce_ff  <= csr_wdata[mphc_pkg::DEB_BITS-1:0];
               default: begin
               end
            endcase
         end
         started_ff    <= started_in;
         tank_empty_ff <= tank_empty_in;
         pump_ff       <= pump_in;
         pend_ff       <= pend_in;
         target_ff     <= target_in;
         settle_ff     <= settle_in;
         since_ctl_ff  <= since_ctl_in;
         since_rep_ff  <= since_rep_in;
         elapsed_ff    <= elapsed_in;
         due_ff        <= due_in;
         mask_ff       <= mask_in;
      end
      adc_ff     <= adc_in;
      tank_ev_ff <= tank_ev_in;
      rep_pct_ff <= rep_pct_in;
   end

   // lowest pending result goes out first
   always_comb begin
      rsp_humidity_report = '0;
      if (mask_ff[0]) begin
         cur_ev = tank_ev_ff;
      end else if (mask_ff[1]) begin
         cur_ev              = mphc_pkg::EV_REPORT;
         rsp_humidity_report = rep_pct_ff;
      end else if (mask_ff[2]) begin
         cur_ev = mphc_pkg::EV_START;
      end else begin
         cur_ev = mphc_pkg::EV_NONE;
      end
   end

   assign rsp_event_res   = cur_ev;
   assign rsp_pump_on     = pump_ff;
   assign rsp_last        = (mask_ff & (mask_ff - 3'd1)) == 3'd0;
   assign status.ctl_due  = due_ff;
   assign status.div_done = div_done;
   assign status.last     = rsp_last;

endmodule

>>> sv/mphc_ctrl.sv
// ----------------------------------------------------------------------------
// mphc_ctrl
// sequencer: take a tick, run the percent divide on control steps, then
// hand out the tick's results one transfer at a time
// ----------------------------------------------------------------------------
module mphc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  mphc_pkg::status_type  status,
   output mphc_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.ctl_due) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.apply = 1'b1;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.pop = 1'b1;
               if (status.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sim/moisture_pump_hysteresis_controller_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moisture_pump_hysteresis_controller_top_tb
// self-checking bench for the moisture pump controller: a table of directed
// ticks and register writes, then random float and moisture traffic under
// several register settings, every response checked against the table's expected values or a tick predictor
// ----------------------------------------------------------------------------
module moisture_pump_hysteresis_controller_top_tb;

   localparam int NUM_ROWS       = 35;
   localparam int NUM_PHASES     = 6;
   localparam int PHASE_TICKS    = 16;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TAIL_CYCLES    = 30;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic                          pump;
      mphc_pkg::event_type           ev;
      logic [mphc_pkg::PCT_BITS-1:0] hum;
      logic                          last;
   } reply_type;

   typedef struct packed {
      logic                          is_write;
      mphc_pkg::reg_index_type       idx;
      logic [15:0]                   data;
      logic                          low;
      logic                          moved;
      logic [mphc_pkg::ADC_BITS-1:0] adc;
      logic                          typed;
      reply_type                     known;
   } plan_row_type;

   typedef struct packed {
      logic [mphc_pkg::ADC_BITS-1:0]    wet;
      logic [mphc_pkg::ADC_BITS-1:0]    dry;
      logic [mphc_pkg::PCT_BITS-1:0]    start_pct;
      logic [mphc_pkg::PCT_BITS-1:0]    stop_pct;
      logic [mphc_pkg::PERIOD_BITS-1:0] max_on;
      logic [mphc_pkg::PERIOD_BITS-1:0] ctl_period;
      logic [mphc_pkg::PERIOD_BITS-1:0] rpt_period;
      logic [mphc_pkg::DEB_BITS-1:0]    settle_ticks;
   } settings_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_we = 1'b0;
   logic [mphc_pkg::CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [mphc_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic                               req_float_low = 1'b0;
   logic                               req_float_edge = 1'b0;
   logic [mphc_pkg::ADC_BITS-1:0]      req_moisture_adc = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic                               rsp_pump_on;
   logic [2:0]                         rsp_event_res;
   logic [mphc_pkg::PCT_BITS-1:0]      rsp_humidity_report;
   logic                               rsp_last;

   moisture_pump_hysteresis_controller_top dut (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_float_low       (req_float_low),
      .req_float_edge      (req_float_edge),
      .req_moisture_adc    (req_moisture_adc),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pump_on         (rsp_pump_on),
      .rsp_event_res       (rsp_event_res),
      .rsp_humidity_report (rsp_humidity_report),
      .rsp_last            (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state and its copy of the registers
   settings_type                     cfg;
   logic                             seen_first;
   logic                             tank_dry;
   logic                             pump_run;
   logic                             settle_wait;
   logic                             settle_level;
   logic [mphc_pkg::DEB_BITS-1:0]    settle_left;
   logic [mphc_pkg::TIMER_BITS-1:0]  ctl_timer;
   logic [mphc_pkg::TIMER_BITS-1:0]  report_timer;
   logic [mphc_pkg::TIMER_BITS-1:0]  run_timer;

   reply_type pending_replies[$];
   int        mismatch_count = 0;
   int        ticks_sent = 0;
   int        replies_checked = 0;
   int        ev_seen [5] = '{default: 0};
   int        send_idle_pct = 0;
   int        rcv_idle_pct = 0;
   int        stall_cycles = 0;
   logic      float_now = 1'b0;

   function automatic logic [mphc_pkg::TIMER_BITS-1:0] sat_inc(
      input logic [mphc_pkg::TIMER_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [mphc_pkg::PCT_BITS-1:0] soil_percent(
      input logic [mphc_pkg::ADC_BITS-1:0] adc);
      int q;
      if (cfg.wet == cfg.dry) return '0;
      q = ((int'(cfg.dry) - int'(adc)) * 100) / (int'(cfg.dry) - int'(cfg.wet));
      if (q < 0) q = 0;
      if (q > 100) q = 100;
      return mphc_pkg::PCT_BITS'(q);
   endfunction

   function automatic void store_register(input mphc_pkg::reg_index_type idx,
                                          input logic [15:0] data);
      case (idx)
         mphc_pkg::REG_WET:      cfg.wet = data[mphc_pkg::ADC_BITS-1:0];
         mphc_pkg::REG_DRY:      cfg.dry = data[mphc_pkg::ADC_BITS-1:0];
         mphc_pkg::REG_START:    cfg.start_pct = data[mphc_pkg::PCT_BITS-1:0];
         mphc_pkg::REG_STOP:     cfg.stop_pct = data[mphc_pkg::PCT_BITS-1:0];
         mphc_pkg::REG_MAX_ON:   cfg.max_on = data[mphc_pkg::PERIOD_BITS-1:0];
         mphc_pkg::REG_CONTROL:  cfg.ctl_period = data[mphc_pkg::PERIOD_BITS-1:0];
         mphc_pkg::REG_REPORT:   cfg.rpt_period = data[mphc_pkg::PERIOD_BITS-1:0];
         mphc_pkg::REG_DEBOUNCE: cfg.settle_ticks = data[mphc_pkg::DEB_BITS-1:0];
         default: ;
      endcase
   endfunction

   function automatic void clear_controller();
      cfg.wet          = mphc_pkg::RST_WET;
      cfg.dry          = mphc_pkg::RST_DRY;
      cfg.start_pct    = mphc_pkg::RST_START;
      cfg.stop_pct     = mphc_pkg::RST_STOP;
      cfg.max_on       = mphc_pkg::RST_MAX_ON;
      cfg.ctl_period   = mphc_pkg::RST_CONTROL;
      cfg.rpt_period   = mphc_pkg::RST_REPORT;
      cfg.settle_ticks = mphc_pkg::RST_DEBOUNCE;
      seen_first   = 1'b0;
      tank_dry     = 1'b0;
      pump_run     = 1'b0;
      settle_wait  = 1'b0;
      settle_level = 1'b0;
      settle_left  = '0;
      ctl_timer    = '0;
      report_timer = '0;
      run_timer    = '0;
   endfunction

   // one millisecond tick of the controller; queues its responses when keep is set
   function automatic void advance_controller(input logic low, input logic moved,
                                              input logic [mphc_pkg::ADC_BITS-1:0] adc,
                                              input bit keep);
      mphc_pkg::event_type           ev_list [3];
      logic [mphc_pkg::PCT_BITS-1:0] hum_list [3];
      logic [mphc_pkg::PCT_BITS-1:0] pct;
      logic                          prev;
      reply_type                     r;
      int                            n;
      n = 0;
      if (!seen_first) begin
         seen_first = 1'b1;
         tank_dry = low;
      end else begin
         ctl_timer = sat_inc(ctl_timer);
         report_timer = sat_inc(report_timer);
         if (pump_run) run_timer = sat_inc(run_timer);
         if (moved) begin
            settle_wait = 1'b1;
            settle_level = low;
            settle_left = cfg.settle_ticks;
         end
         if (settle_wait) begin
            if (settle_left == '0) begin
               settle_wait = 1'b0;
               if (low == settle_level) begin
                  prev = tank_dry;
                  tank_dry = low;
                  if (!prev && low) begin
                     ev_list[n] = mphc_pkg::EV_EMPTY;
                     hum_list[n] = '0;
                     n++;
                     pump_run = 1'b0;
                  end else if (prev && !low) begin
                     ev_list[n] = mphc_pkg::EV_REFILL;
                     hum_list[n] = '0;
                     n++;
                  end
               end
            end else begin
               settle_left = settle_left - 1'b1;
            end
         end
         if (ctl_timer >= cfg.ctl_period) begin
            pct = soil_percent(adc);
            ctl_timer = '0;
            if (report_timer >= cfg.rpt_period) begin
               report_timer = '0;
               ev_list[n] = mphc_pkg::EV_REPORT;
               hum_list[n] = (pct > mphc_pkg::REPORT_CLAMP) ? mphc_pkg::REPORT_CLAMP : pct;
               n++;
            end
            if (!pump_run) begin
               if (!tank_dry && pct <= cfg.start_pct) begin
                  pump_run = 1'b1;
                  run_timer = '0;
                  ev_list[n] = mphc_pkg::EV_START;
                  hum_list[n] = '0;
                  n++;
               end
            end else if (run_timer >= cfg.max_on || pct >= cfg.stop_pct || tank_dry) begin
               pump_run = 1'b0;
            end
         end
      end
      if (n == 0) begin
         ev_list[0] = mphc_pkg::EV_NONE;
         hum_list[0] = '0;
         n = 1;
      end
      if (keep) begin
         for (int i = 0; i < n; i++) begin
            r.pump = pump_run;
            r.ev   = ev_list[i];
            r.hum  = hum_list[i];
            r.last = (i == n - 1);
            pending_replies.push_back(r);
         end
      end
   endfunction

   function automatic plan_row_type tick_row(input logic low, input logic moved,
                                             input logic [mphc_pkg::ADC_BITS-1:0] adc);
      plan_row_type row;
      row = '0;
      row.low = low;
      row.moved = moved;
      row.adc = adc;
      return row;
   endfunction

   function automatic plan_row_type known_row(input logic low, input logic moved,
                                              input logic [mphc_pkg::ADC_BITS-1:0] adc,
                                              input logic pump,
                                              input mphc_pkg::event_type ev,
                                              input logic [mphc_pkg::PCT_BITS-1:0] hum);
      plan_row_type row;
      row = tick_row(low, moved, adc);
      row.typed = 1'b1;
      row.known.pump = pump;
      row.known.ev = ev;
      row.known.hum = hum;
      row.known.last = 1'b1;
      return row;
   endfunction

   function automatic plan_row_type write_row(input mphc_pkg::reg_index_type idx,
                                              input logic [15:0] data);
      plan_row_type row;
      row = '0;
      row.is_write = 1'b1;
      row.idx = idx;
      row.data = data;
      return row;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_tick(input logic low, input logic moved,
                            input logic [mphc_pkg::ADC_BITS-1:0] adc,
                            input logic typed, input reply_type known);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_float_low    <= low;
      req_float_edge   <= moved;
      req_moisture_adc <= adc;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_controller(low, moved, adc, !typed);
      if (typed) pending_replies.push_back(known);
      ticks_sent++;
   endtask

   task automatic random_tick();
      int                            roll;
      logic                          moved;
      logic [mphc_pkg::ADC_BITS-1:0] adc;
      roll = $urandom_range(0, 15);
      moved = 1'b0;
      if ((!float_now && roll == 0) || (float_now && roll < 4)) begin
         float_now = !float_now;
         moved = 1'b1;
      end else if (roll == 4) begin
         // edge without a level change
         moved = 1'b1;
      end else if (roll == 5) begin
         // level change that the edge detector missed
         float_now = !float_now;
      end
      if ($urandom_range(0, 1) == 0) begin
         adc = mphc_pkg::ADC_BITS'($urandom_range(cfg.wet, cfg.dry));
      end else begin
         adc = mphc_pkg::ADC_BITS'($urandom_range(0, 4095));
      end
      send_tick(float_now, moved, adc, 1'b0, '0);
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input mphc_pkg::reg_index_type idx, input logic [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      store_register(idx, data);
   endtask

   // response checker and receiver stalls
   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            replies_checked++;
            if (rsp_event_res <= mphc_pkg::EV_START) ev_seen[rsp_event_res]++;
            if (pending_replies.size() == 0) begin
               report_mismatch("response with nothing expected, event", rsp_event_res, -1);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_pump_on !== want.pump)
                  report_mismatch("pump_on", rsp_pump_on, want.pump);
               if (rsp_event_res !== want.ev)
                  report_mismatch("event_res", rsp_event_res, want.ev);
               if (rsp_humidity_report !== want.hum)
                  report_mismatch("humidity_report", rsp_humidity_report, want.hum);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d responses outstanding",
                     stall_cycles, pending_replies.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      plan_row_type            plan [NUM_ROWS];
      logic [15:0]             vals [8];
      mphc_pkg::reg_index_type r;

      clear_controller();
      plan = '{
         known_row(1'b1, 1'b1, 12'd0, 1'b0, mphc_pkg::EV_NONE, 7'd0),
         known_row(1'b1, 1'b0, 12'd4095, 1'b0, mphc_pkg::EV_NONE, 7'd0),
         write_row(mphc_pkg::REG_WET, 16'd1000),
         write_row(mphc_pkg::REG_DRY, 16'd3000),
         write_row(mphc_pkg::REG_CONTROL, 16'd1),
         write_row(mphc_pkg::REG_REPORT, 16'd2),
         write_row(mphc_pkg::REG_DEBOUNCE, 16'd0),
         known_row(1'b1, 1'b0, 12'd0, 1'b0, mphc_pkg::EV_REPORT, 7'd99),
         tick_row(1'b0, 1'b1, 12'd4095),
         known_row(1'b0, 1'b0, 12'd0, 1'b0, mphc_pkg::EV_REPORT, 7'd99),
         write_row(mphc_pkg::REG_MAX_ON, 16'd0),
         known_row(1'b0, 1'b0, 12'd3000, 1'b1, mphc_pkg::EV_START, 7'd0),
         tick_row(1'b0, 1'b0, 12'd3000),
         write_row(mphc_pkg::REG_MAX_ON, 16'hFFFF),
         write_row(mphc_pkg::REG_START, 16'd127),
         write_row(mphc_pkg::REG_STOP, 16'd127),
         tick_row(1'b0, 1'b0, 12'd4095),
         tick_row(1'b1, 1'b1, 12'd4095),
         write_row(mphc_pkg::REG_DEBOUNCE, 16'd3),
         tick_row(1'b0, 1'b1, 12'd0),
         tick_row(1'b1, 1'b1, 12'd0),
         tick_row(1'b1, 1'b0, 12'd0),
         tick_row(1'b1, 1'b0, 12'd0),
         tick_row(1'b1, 1'b0, 12'd0),
         tick_row(1'b0, 1'b1, 12'd2000),
         tick_row(1'b0, 1'b0, 12'd2000),
         tick_row(1'b0, 1'b0, 12'd2000),
         tick_row(1'b0, 1'b0, 12'd2000),
         tick_row(1'b1, 1'b1, 12'd2000),
         tick_row(1'b0, 1'b0, 12'd2000),
         tick_row(1'b0, 1'b0, 12'd2000),
         tick_row(1'b0, 1'b0, 12'd2000),
         write_row(mphc_pkg::REG_WET, 16'd2048),
         write_row(mphc_pkg::REG_DRY, 16'd2048),
         tick_row(1'b0, 1'b0, 12'd100)
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      send_idle_pct = 20;
      rcv_idle_pct  = 64;
      foreach (plan[i]) begin
         if (plan[i].is_write) begin
            drain_replies();
            write_register(plan[i].idx, plan[i].data);
            csr_we <= 1'b0;
         end else begin
            send_tick(plan[i].low, plan[i].moved, plan[i].adc, plan[i].typed, plan[i].known);
         end
      end
      float_now = 1'b0;

      // random traffic, one register setting per phase
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: vals = '{16'($urandom_range(1, 1500)), 16'($urandom_range(2500, 4095)),
                        16'd35, 16'd45, 16'd5, 16'd1, 16'd3, 16'd2};
            1: vals = '{16'd4095, 16'd1, 16'd0, 16'd100, 16'hFFFF, 16'd2, 16'd1, 16'd0};
            2: vals = '{16'($urandom_range(1, 4095)), 16'($urandom_range(1, 4095)),
                        16'($urandom_range(0, 100)), 16'($urandom_range(0, 100)),
                        16'($urandom_range(1, 8)), 16'd0, 16'd0, 16'd1023};
            3: vals = '{16'd1, 16'd4095, 16'($urandom_range(0, 127)),
                        16'($urandom_range(0, 127)), 16'($urandom_range(0, 20)),
                        16'hFFFF, 16'hFFFF, 16'($urandom_range(0, 5))};
            default: vals = '{16'($urandom_range(1, 4095)), 16'($urandom_range(1, 4095)),
                              16'($urandom_range(0, 127)), 16'($urandom_range(0, 127)),
                              16'($urandom_range(0, 10)), 16'($urandom_range(0, 4)),
                              16'($urandom_range(0, 6)), 16'($urandom_range(0, 4))};
         endcase
         if (ph < 2) begin
            send_idle_pct = 20;
            rcv_idle_pct  = 64;
         end else if (ph < 4) begin
            send_idle_pct = 64;
            rcv_idle_pct  = 20;
         end else begin
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
         end
         drain_replies();
         r = r.first();
         do begin
            write_register(r, vals[r]);
            r = r.next();
         end while (r != r.first());
         csr_we <= 1'b0;
         for (int k = 0; k < PHASE_TICKS; k++) random_tick();
      end

      drain_replies();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d ticks over the directed table and %0d register settings, %0d responses checked",
               ticks_sent, NUM_PHASES, replies_checked);
      $display("events seen: empty %0d, refill %0d, report %0d, start %0d, none %0d",
               ev_seen[mphc_pkg::EV_EMPTY], ev_seen[mphc_pkg::EV_REFILL],
               ev_seen[mphc_pkg::EV_REPORT], ev_seen[mphc_pkg::EV_START],
               ev_seen[mphc_pkg::EV_NONE]);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
